// ----- rtl/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths, payload types and the controller/datapath command and status
// groups of the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int CFG_W         = 7;
	localparam int SAMPLE_PORT_W = 32;
	localparam int MEDIAN_W      = 33;

	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

	typedef struct packed {
		logic signed [SAMPLE_PORT_W-1:0] sample;
		logic                            start_of_sequence;
	} sample_item_t;

	typedef struct packed {
		logic signed [MEDIAN_W-1:0] median_doubled;
	} result_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_step;
		logic rd_mid_hi;
		logic rd_mid_lo;
		logic take_lo;
		logic emit;
	} swm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic has_result;
		logic out_free;
	} swm_stat_t;

endpackage

// ----- rtl/swm_stream_if.sv -----
// ----------------------------------------------------------------------------
// swm_stream_if
// Valid/ready stream channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface swm_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/swm_controller.sv -----
// ----------------------------------------------------------------------------
// swm_controller
// Sequencer for one sample: take it, run the sorted store update scan, read
// the middle entries and hand the result to the output register.
// ----------------------------------------------------------------------------
module swm_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  swm_pkg::swm_stat_t stat,
	output swm_pkg::swm_cmd_t  cmd
);
	import swm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MED_HI,
		S_MED_LO,
		S_MED_GET,
		S_DRAIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (stat.scan_done) begin
						state_q <= stat.has_result ? S_MED_HI : S_IDLE;
					end
				end
				S_MED_HI:  state_q <= S_MED_LO;
				S_MED_LO:  state_q <= S_MED_GET;
				S_MED_GET: state_q <= S_DRAIN;
				S_DRAIN: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == S_IDLE) && in_valid;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.rd_mid_hi = (state_q == S_MED_HI);
		cmd.rd_mid_lo = (state_q == S_MED_LO);
		cmd.take_lo   = (state_q == S_MED_GET);
		cmd.emit      = (state_q == S_DRAIN) && stat.out_free;
	end

endmodule

// ----- rtl/swm_datapath.sv -----
// ----------------------------------------------------------------------------
// swm_datapath
// Arrival ring and sorted store memories, the merge scan that removes the
// oldest sample and inserts the new one, median read-out and output register.
// ----------------------------------------------------------------------------
module swm_datapath #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [swm_pkg::CFG_W-1:0]   cfg_wdata,
	input  swm_pkg::sample_item_t       in_data,
	input  swm_pkg::swm_cmd_t           cmd,
	output swm_pkg::swm_stat_t          stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output swm_pkg::result_item_t       out_data
);
	import swm_pkg::*;

	localparam int AW = $clog2(WINDOW_MAX);
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int EW = (CW > CFG_W) ? CW : CFG_W;
	localparam int SW = SAMPLE_WIDTH;

	typedef enum logic [1:0] {
		M_NORMAL,
		M_RIGHT,
		M_LEFT,
		M_DONE
	} mode_t;

	// configuration and window bookkeeping
	logic [CFG_W-1:0] window_q;
	logic [CW-1:0]    fill_q;
	logic [AW-1:0]    ptr_q;
	logic [CW-1:0]    n_q;
	logic             rem_q;
	logic             has_res_q;

	// scan state
	mode_t            mode_q, mode_d;
	logic [CW-1:0]    rd_idx_q;
	logic             v_s1;
	logic [CW-1:0]    idx_s1;
	logic signed [SW-1:0] x_q;
	logic signed [SW-1:0] carry_q, carry_d;

	// memories and their read registers
	logic signed [SW-1:0] arrival_q [WINDOW_MAX];
	logic signed [SW-1:0] sorted_q  [WINDOW_MAX];
	logic signed [SW-1:0] arr_rd_q;
	logic signed [SW-1:0] srt_rd_q;

	logic signed [SW-1:0] hi_q, lo_q;
	logic                 out_valid_q;
	result_item_t         out_q;

	logic [EW-1:0]        wcfg_x;
	logic [CW-1:0]        w_eff, w_m1, w_half;
	logic [AW-1:0]        mid_hi_a, mid_lo_a;
	logic [CW-1:0]        fill_eff, fill_inc;
	logic [AW-1:0]        ptr_eff, ptr_next;
	logic                 rem_d;
	logic signed [SW-1:0] x_in;
	logic [AW-1:0]        arr_wa;

	logic                 srt_issue, srt_re, srt_we;
	logic [AW-1:0]        srt_ra, srt_wa;
	logic signed [SW-1:0] srt_wd;
	logic [CW-1:0]        idx_m1, n_m1;
	logic                 scan_done;

	logic signed [SW:0]   hi_x, lo_x, sum_d;

	// a zero window acts as one, a window above capacity saturates
	assign wcfg_x = EW'(window_q);
	always_comb begin
		if (window_q == '0) begin
			w_eff = CW'(1);
		end else if (wcfg_x > EW'(WINDOW_MAX)) begin
			w_eff = CW'(WINDOW_MAX);
		end else begin
			w_eff = wcfg_x[CW-1:0];
		end
	end

	assign w_m1     = w_eff - CW'(1);
	assign w_half   = w_eff >> 1;
	assign mid_hi_a = w_half[AW-1:0];
	assign mid_lo_a = w_eff[0] ? mid_hi_a : mid_hi_a - AW'(1);

	assign x_in     = $signed(in_data.sample[SW-1:0]);
	assign fill_eff = in_data.start_of_sequence ? '0 : fill_q;
	assign ptr_eff  = in_data.start_of_sequence ? '0 : ptr_q;
	assign fill_inc = fill_eff + CW'(1);
	assign rem_d    = (fill_eff >= w_eff);
	assign ptr_next = (ptr_eff == w_m1[AW-1:0]) ? '0 : ptr_eff + AW'(1);
	assign arr_wa   = rem_d ? ptr_eff : fill_eff[AW-1:0];

	// arrival ring: write the new sample, read the one it replaces
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			arrival_q[arr_wa] <= x_in;
			arr_rd_q          <= arrival_q[ptr_eff];
		end
	end

	assign srt_issue = cmd.scan_step && (rd_idx_q < n_q) && (mode_q != M_DONE);
	assign srt_re    = srt_issue || cmd.rd_mid_hi || cmd.rd_mid_lo;
	always_comb begin
		if (cmd.rd_mid_hi) begin
			srt_ra = mid_hi_a;
		end else if (cmd.rd_mid_lo) begin
			srt_ra = mid_lo_a;
		end else begin
			srt_ra = rd_idx_q[AW-1:0];
		end
	end

	assign scan_done = (mode_q == M_DONE) || (!v_s1 && (rd_idx_q >= n_q));
	assign idx_m1    = idx_s1 - CW'(1);
	assign n_m1      = n_q - CW'(1);

	// merge scan: one stored entry a cycle, writing at its own slot or one below
	always_comb begin
		mode_d  = mode_q;
		carry_d = carry_q;
		srt_we  = 1'b0;
		srt_wa  = idx_s1[AW-1:0];
		srt_wd  = x_q;
		if (cmd.scan_step) begin
			if (v_s1 && (mode_q != M_DONE)) begin
				case (mode_q)
					M_NORMAL: begin
						if (rem_q && (srt_rd_q == arr_rd_q)) begin
							mode_d = M_LEFT;
						end else if (x_q < srt_rd_q) begin
							srt_we  = 1'b1;
							srt_wd  = x_q;
							carry_d = srt_rd_q;
							mode_d  = M_RIGHT;
						end
					end
					M_RIGHT: begin
						srt_we = 1'b1;
						srt_wd = carry_q;
						if (rem_q && (srt_rd_q == arr_rd_q)) begin
							mode_d = M_DONE;
						end else begin
							carry_d = srt_rd_q;
						end
					end
					M_LEFT: begin
						srt_we = 1'b1;
						srt_wa = idx_m1[AW-1:0];
						if (x_q < srt_rd_q) begin
							srt_wd = x_q;
							mode_d = M_DONE;
						end else begin
							srt_wd = srt_rd_q;
						end
					end
					default: begin
						mode_d = mode_q;
					end
				endcase
			end else if (scan_done && (mode_q != M_DONE)) begin
				// new sample or carried entry lands past the last one read, or on it when shifting left
				case (mode_q)
					M_NORMAL: begin
						srt_we = !rem_q;
						srt_wa = n_q[AW-1:0];
						srt_wd = x_q;
					end
					M_RIGHT: begin
						srt_we = !rem_q;
						srt_wa = n_q[AW-1:0];
						srt_wd = carry_q;
					end
					M_LEFT: begin
						srt_we = 1'b1;
						srt_wa = n_m1[AW-1:0];
						srt_wd = x_q;
					end
					default: begin
						srt_we = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (srt_we) begin
			sorted_q[srt_wa] <= srt_wd;
		end
		if (srt_re) begin
			srt_rd_q <= sorted_q[srt_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			fill_q      <= '0;
			ptr_q       <= '0;
			n_q         <= '0;
			rem_q       <= 1'b0;
			has_res_q   <= 1'b0;
			mode_q      <= M_DONE;
			rd_idx_q    <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
				fill_q   <= '0;
				ptr_q    <= '0;
			end
			if (cmd.accept) begin
				fill_q    <= rem_d ? fill_eff : fill_inc;
				ptr_q     <= rem_d ? ptr_next : ptr_eff;
				n_q       <= fill_eff;
				rem_q     <= rem_d;
				has_res_q <= rem_d || (fill_inc == w_eff);
				mode_q    <= M_NORMAL;
				rd_idx_q  <= '0;
				v_s1      <= 1'b0;
			end else if (cmd.scan_step) begin
				mode_q <= mode_d;
				v_s1   <= srt_issue;
				if (srt_issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign hi_x  = {hi_q[SW-1], hi_q};
	assign lo_x  = w_eff[0] ? {hi_q[SW-1], hi_q} : {lo_q[SW-1], lo_q};
	assign sum_d = hi_x + lo_x;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q <= x_in;
		end
		if (cmd.scan_step) begin
			carry_q <= carry_d;
			if (srt_issue) begin
				idx_s1 <= rd_idx_q;
			end
		end
		if (cmd.rd_mid_lo) begin
			hi_q <= srt_rd_q;
		end
		if (cmd.take_lo) begin
			lo_q <= srt_rd_q;
		end
		if (cmd.emit) begin
			out_q.median_doubled <= MEDIAN_W'($unsigned(sum_d));
		end
	end

	assign stat.scan_done  = scan_done;
	assign stat.has_result = has_res_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/sliding_window_median_top.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Running median filter over the last window length samples, result given as
// twice the median (one fractional bit).
//
//   channel    role      payload
//   samples    sink      sample, start_of_sequence
//   medians    source    median_doubled
//   cfg_we     write     cfg_wdata = window length
//
// A sample runs the merge scan through the sorted store, one entry a cycle on
// its single read port, so its time grows with the samples already held; when
// it yields a result, the median read-out and output handover follow. A new
// transaction is taken only in the idle state; a finished result waits in the
// output register while the next sample runs. Reset empties the window and
// sets the window length to 3; the stores need no clearing pass. A stalled
// output holds the block only at the final handover.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
	swm_stream_if.sink                samples,
	swm_stream_if.source              medians
);
	import swm_pkg::*;

	swm_cmd_t     cmd;
	swm_stat_t    stat;
	logic         in_ready;
	logic         out_valid;
	result_item_t out_data;

	swm_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	swm_datapath #(
		.WINDOW_MAX   (WINDOW_MAX),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (samples.data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (medians.ready),
		.out_data  (out_data)
	);

	assign samples.ready = in_ready;
	assign medians.valid = out_valid;
	assign medians.data  = out_data;

endmodule
